@@ src/assert_macros.svh @@
// assertion macros shared by the mip chain blocks
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MMBD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MMBD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mmbd_pkg.sv @@
// types and constants of the mip chain 2x2 box downsampler
// no dependencies; used by every module of the block
package mmbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_LEVELS = 12;

    localparam int COORD_W   = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = COORD_W;
    localparam int LVL_IDX_W = $clog2(MAX_LEVELS);

    localparam int DIM_W     = 13;
    localparam int CHCNT_W   = 3;
    localparam int LEVEL_W   = 4;
    localparam int POS_W     = 11;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int PAIR_CH_W = CH_W + 1;
    localparam int PAIR_W    = PAIR_CH_W * NUM_CH;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [DIM_W-1:0]   DIM_MAX   = DIM_W'(MAX_WIDTH);
    localparam logic [CHCNT_W-1:0] CH_MAX    = CHCNT_W'(NUM_CH);

    // small queues between front, level engine and result side
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    typedef struct packed {
        coord_t           x;
        coord_t           y;
        logic [PIX_W-1:0] px;
    } job_t;

    typedef struct packed {
        level_t           level;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [PIX_W-1:0] px;
        logic             last;
    } result_t;

endpackage

@@ src/mmbd_front.sv @@
// front end: configuration registers, base raster position and channel masking
// depends on mmbd_pkg
module mmbd_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [mmbd_pkg::CH_W-1:0]            pix_c0,
    input  logic [mmbd_pkg::CH_W-1:0]            pix_c1,
    input  logic [mmbd_pkg::CH_W-1:0]            pix_c2,
    input  logic [mmbd_pkg::CH_W-1:0]            pix_c3,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmbd_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                 job_full,
    output logic                                 job_push,
    output mmbd_pkg::job_t                       job,
    output mmbd_pkg::dims_t                      dims,
    output logic                                 restart
);

    logic [mmbd_pkg::DIM_W-1:0]   width_reg;
    logic [mmbd_pkg::DIM_W-1:0]   height_reg;
    logic [mmbd_pkg::CHCNT_W-1:0] chans_reg;
    mmbd_pkg::coord_t             col_reg;
    mmbd_pkg::coord_t             row_reg;
    logic                         last_col;
    logic                         last_row;
    logic [mmbd_pkg::PIX_W-1:0]   raw_px;
    logic [mmbd_pkg::PIX_W-1:0]   masked_px;

    function automatic logic [mmbd_pkg::DIM_W-1:0] eff_dim(logic [mmbd_pkg::DIM_W-1:0] v);
        logic [mmbd_pkg::DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = mmbd_pkg::DIM_W'(1);
        else if (v > mmbd_pkg::DIM_MAX)
            r = mmbd_pkg::DIM_MAX;
        return r;
    endfunction

    function automatic logic [mmbd_pkg::CHCNT_W-1:0] eff_chans(
        logic [mmbd_pkg::CHCNT_W-1:0] v
    );
        logic [mmbd_pkg::CHCNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = mmbd_pkg::CHCNT_W'(1);
        else if (v > mmbd_pkg::CH_MAX)
            r = mmbd_pkg::CH_MAX;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && ((cfg_index == mmbd_pkg::REG_IMAGE_WIDTH) ||
                                     (cfg_index == mmbd_pkg::REG_IMAGE_HEIGHT) ||
                                     (cfg_index == mmbd_pkg::REG_CHANNEL_COUNT));

    assign job_push  = push && !job_full;
    assign last_col  = ({1'b0, col_reg} == (width_reg - mmbd_pkg::DIM_W'(1)));
    assign last_row  = ({1'b0, row_reg} == (height_reg - mmbd_pkg::DIM_W'(1)));

    assign raw_px = {pix_c3, pix_c2, pix_c1, pix_c0};

    // channels at or above the channel count read as zero
    always_comb
    begin
        for (int c = 0; c < mmbd_pkg::NUM_CH; c++)
        begin
            if (mmbd_pkg::CHCNT_W'(c) < chans_reg)
                masked_px[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W] =
                    raw_px[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W];
            else
                masked_px[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W] = '0;
        end
    end

    assign job.x  = col_reg;
    assign job.y  = row_reg;
    assign job.px = masked_px;

    assign dims.width  = width_reg;
    assign dims.height = height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mmbd_pkg::DIM_MAX;
            height_reg <= mmbd_pkg::DIM_MAX;
            chans_reg  <= mmbd_pkg::CH_MAX;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (restart)
        begin
            case (cfg_index)
                mmbd_pkg::REG_IMAGE_WIDTH:   width_reg  <= eff_dim(cfg_data);
                mmbd_pkg::REG_IMAGE_HEIGHT:  height_reg <= eff_dim(cfg_data);
                mmbd_pkg::REG_CHANNEL_COUNT:
                    chans_reg <= eff_chans(cfg_data[mmbd_pkg::CHCNT_W-1:0]);
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (job_push)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + mmbd_pkg::COORD_W'(1);
            end
            else
            begin
                col_reg <= col_reg + mmbd_pkg::COORD_W'(1);
            end
        end
    end

endmodule

@@ src/mmbd_job_queue.sv @@
// four-entry request queue between the front end and the level engine
// depends on mmbd_pkg
module mmbd_job_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mmbd_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output mmbd_pkg::job_t dout,
    output logic           empty
);

    mmbd_pkg::job_t                entries_reg [mmbd_pkg::QUEUE_DEPTH];
    logic [mmbd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mmbd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mmbd_pkg::QCNT_W-1:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == mmbd_pkg::QCNT_W'(mmbd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + mmbd_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + mmbd_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + mmbd_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - mmbd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= din;
    end

endmodule

@@ src/mmbd_back.sv @@
// level engine: one level step per cycle unless held by a full result queue; pair-sum memory and held left pixels
// depends on mmbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmbd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mmbd_pkg::dims_t   dims,
    input  logic              restart,
    input  mmbd_pkg::job_t    job,
    input  logic              job_empty,
    output logic              job_pop,
    output mmbd_pkg::result_t res,
    output logic              res_push,
    input  logic              res_full
);

    // current level step
    logic                            j_valid_reg;
    mmbd_pkg::level_t                j_level_reg;
    mmbd_pkg::coord_t                j_x_reg;
    mmbd_pkg::coord_t                j_y_reg;
    logic [mmbd_pkg::PIX_W-1:0]      j_px_reg;

    logic [mmbd_pkg::PAIR_W-1:0]     pair_mem [mmbd_pkg::MAX_WIDTH];
    logic [mmbd_pkg::PAIR_W-1:0]     rd_data_reg;
    logic [mmbd_pkg::PIX_W-1:0]      held_reg [mmbd_pkg::MAX_LEVELS];
    logic [mmbd_pkg::POS_W-1:0]      lcc_reg [mmbd_pkg::MAX_LEVELS];
    logic [mmbd_pkg::POS_W-1:0]      lrc_reg [mmbd_pkg::MAX_LEVELS];

    logic [mmbd_pkg::LVL_IDX_W-1:0]  cur_i;
    logic [mmbd_pkg::LVL_IDX_W-1:0]  nxt_i;
    logic                            cur_ok;
    logic                            emit;
    logic [mmbd_pkg::PAIR_W-1:0]     cur_pair;
    logic [mmbd_pkg::PIX_W-1:0]      avg;
    logic                            has_next;
    mmbd_pkg::level_t                nxt_level;
    mmbd_pkg::coord_t                nxt_x;
    mmbd_pkg::coord_t                nxt_y;
    logic                            nxt_ok;
    logic                            nxt_emit;
    logic                            j_fire;
    logic                            cascade;
    logic                            take;

    logic                            held_we;
    logic [mmbd_pkg::LVL_IDX_W-1:0]  held_wi;
    logic [mmbd_pkg::PIX_W-1:0]      held_wd;
    logic                            mem_we;
    logic [mmbd_pkg::ADDR_W-1:0]     mem_wa;
    logic [mmbd_pkg::PAIR_W-1:0]     mem_wd;
    logic                            mem_re;
    logic [mmbd_pkg::ADDR_W-1:0]     mem_ra;

    mmbd_pkg::coord_t                lw_cur;
    mmbd_pkg::coord_t                lh_cur;
    mmbd_pkg::coord_t                col_inc;
    mmbd_pkg::coord_t                row_inc;

    function automatic mmbd_pkg::coord_t level_dim(
        logic [mmbd_pkg::DIM_W-1:0] dim,
        mmbd_pkg::level_t           lvl
    );
        logic [mmbd_pkg::DIM_W-1:0] sh;
        sh = dim >> lvl;
        return sh[mmbd_pkg::COORD_W-1:0];
    endfunction

    // position lies inside the 2x2 blocks that make up this level
    function automatic logic in_level(
        mmbd_pkg::coord_t x,
        mmbd_pkg::coord_t y,
        mmbd_pkg::dims_t  d,
        mmbd_pkg::level_t lvl
    );
        mmbd_pkg::coord_t lw;
        mmbd_pkg::coord_t lh;
        lw = level_dim(d.width, lvl);
        lh = level_dim(d.height, lvl);
        return (lw != '0) && (lh != '0) &&
               ({1'b0, x} < {lw, 1'b0}) && ({1'b0, y} < {lh, 1'b0});
    endfunction

    // each level owns a region of the pair-sum memory, half the size of the one above
    function automatic logic [mmbd_pkg::ADDR_W-1:0] pair_addr(
        mmbd_pkg::level_t lvl,
        mmbd_pkg::coord_t x
    );
        int base;
        base = mmbd_pkg::MAX_WIDTH - (mmbd_pkg::MAX_WIDTH >> (int'(lvl) - 1));
        return mmbd_pkg::ADDR_W'(base) + mmbd_pkg::ADDR_W'(x >> 1);
    endfunction

    function automatic logic [mmbd_pkg::PAIR_W-1:0] pair_sum(
        logic [mmbd_pkg::PIX_W-1:0] a,
        logic [mmbd_pkg::PIX_W-1:0] b
    );
        logic [mmbd_pkg::PAIR_W-1:0] p;
        for (int c = 0; c < mmbd_pkg::NUM_CH; c++)
            p[c*mmbd_pkg::PAIR_CH_W +: mmbd_pkg::PAIR_CH_W] =
                {1'b0, a[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W]} +
                {1'b0, b[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W]};
        return p;
    endfunction

    function automatic logic [mmbd_pkg::PIX_W-1:0] box_avg(
        logic [mmbd_pkg::PAIR_W-1:0] upper,
        logic [mmbd_pkg::PAIR_W-1:0] lower
    );
        logic [mmbd_pkg::PIX_W-1:0]     r;
        logic [mmbd_pkg::PAIR_CH_W:0]   s;
        for (int c = 0; c < mmbd_pkg::NUM_CH; c++)
        begin
            s = {1'b0, upper[c*mmbd_pkg::PAIR_CH_W +: mmbd_pkg::PAIR_CH_W]} +
                {1'b0, lower[c*mmbd_pkg::PAIR_CH_W +: mmbd_pkg::PAIR_CH_W]};
            r[c*mmbd_pkg::CH_W +: mmbd_pkg::CH_W] = s[mmbd_pkg::PAIR_CH_W:2];
        end
        return r;
    endfunction

    // current step feeds level j_level with a pixel of the level above
    assign cur_i    = mmbd_pkg::LVL_IDX_W'(j_level_reg - mmbd_pkg::LEVEL_W'(1));
    assign cur_ok   = in_level(j_x_reg, j_y_reg, dims, j_level_reg);
    assign cur_pair = pair_sum(held_reg[cur_i], j_px_reg);
    assign emit     = j_valid_reg && cur_ok && j_x_reg[0] && j_y_reg[0];
    assign avg      = box_avg(rd_data_reg, cur_pair);

    // look one level down so that last is known and a non-emitting step is folded in;
    // the pixel just produced sits at this level's output position in the next level's input
    assign has_next  = (j_level_reg < mmbd_pkg::LEVEL_W'(mmbd_pkg::MAX_LEVELS));
    assign nxt_i     = has_next ? mmbd_pkg::LVL_IDX_W'(j_level_reg) : '0;
    assign nxt_level = j_level_reg + mmbd_pkg::LEVEL_W'(1);
    assign nxt_x     = mmbd_pkg::COORD_W'(lcc_reg[cur_i]);
    assign nxt_y     = mmbd_pkg::COORD_W'(lrc_reg[cur_i]);
    assign nxt_ok    = has_next && in_level(nxt_x, nxt_y, dims, nxt_level);
    assign nxt_emit  = nxt_ok && nxt_x[0] && nxt_y[0];

    assign j_fire   = j_valid_reg && (!emit || !res_full);
    assign cascade  = j_fire && emit && nxt_emit;
    assign take     = (!j_valid_reg || (j_fire && !cascade)) && !job_empty;
    assign job_pop  = take;
    assign res_push = emit && !res_full;

    assign res.level = j_level_reg;
    assign res.col   = lcc_reg[cur_i];
    assign res.row   = lrc_reg[cur_i];
    assign res.px    = avg;
    assign res.last  = !nxt_emit;

    always_comb
    begin
        held_we = 1'b0;
        held_wi = cur_i;
        held_wd = j_px_reg;
        mem_we  = 1'b0;
        mem_wa  = pair_addr(j_level_reg, j_x_reg);
        mem_wd  = cur_pair;
        if (j_fire)
        begin
            if (cur_ok && !j_x_reg[0])
            begin
                // left pixel of a pair
                held_we = 1'b1;
            end
            else if (cur_ok && !j_y_reg[0])
            begin
                // upper row of a block
                mem_we = 1'b1;
            end
            else if (emit && nxt_ok && !nxt_x[0])
            begin
                held_we = 1'b1;
                held_wi = nxt_i;
                held_wd = avg;
            end
            else if (emit && nxt_ok && !nxt_y[0])
            begin
                mem_we = 1'b1;
                mem_wa = pair_addr(nxt_level, nxt_x);
                mem_wd = pair_sum(held_reg[nxt_i], avg);
            end
        end
    end

    // read for the step that is loaded at this edge
    assign mem_re = cascade || take;
    assign mem_ra = cascade ? pair_addr(nxt_level, nxt_x)
                            : pair_addr(mmbd_pkg::LEVEL_W'(1), job.x);

    assign lw_cur  = level_dim(dims.width, j_level_reg);
    assign lh_cur  = level_dim(dims.height, j_level_reg);
    assign col_inc = mmbd_pkg::COORD_W'(lcc_reg[cur_i]) + mmbd_pkg::COORD_W'(1);
    assign row_inc = mmbd_pkg::COORD_W'(lrc_reg[cur_i]) + mmbd_pkg::COORD_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg <= 1'b0;
            for (int i = 0; i < mmbd_pkg::MAX_LEVELS; i++)
            begin
                lcc_reg[i] <= '0;
                lrc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cascade || take)
                j_valid_reg <= 1'b1;
            else if (j_fire)
                j_valid_reg <= 1'b0;

            if (restart)
            begin
                for (int i = 0; i < mmbd_pkg::MAX_LEVELS; i++)
                begin
                    lcc_reg[i] <= '0;
                    lrc_reg[i] <= '0;
                end
            end
            else if (res_push)
            begin
                if (col_inc >= lw_cur)
                begin
                    lcc_reg[cur_i] <= '0;
                    lrc_reg[cur_i] <= (row_inc >= lh_cur) ? '0 : row_inc[mmbd_pkg::POS_W-1:0];
                end
                else
                begin
                    lcc_reg[cur_i] <= col_inc[mmbd_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cascade)
        begin
            j_level_reg <= nxt_level;
            j_x_reg     <= nxt_x;
            j_y_reg     <= nxt_y;
            j_px_reg    <= avg;
        end
        else if (take)
        begin
            j_level_reg <= mmbd_pkg::LEVEL_W'(1);
            j_x_reg     <= job.x;
            j_y_reg     <= job.y;
            j_px_reg    <= job.px;
        end
        if (held_we)
            held_reg[held_wi] <= held_wd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pair_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= pair_mem[mem_ra];
    end

    `MMBD_ASSERT_IMP(a_res_room, res_push, !res_full, "result request while result queue full")
    `MMBD_ASSERT_IMP(a_level_range, j_valid_reg, (j_level_reg >= mmbd_pkg::LEVEL_W'(1)) && (j_level_reg <= mmbd_pkg::LEVEL_W'(mmbd_pkg::MAX_LEVELS)), "level step out of range")
    `MMBD_ASSERT_NXT(a_cascade_step, cascade, j_valid_reg && (j_level_reg == $past(j_level_reg) + mmbd_pkg::LEVEL_W'(1)), "cascade did not advance one level")

endmodule

@@ src/mmbd_out_queue.sv @@
// four-entry result queue, head drives the result ports
// depends on mmbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmbd_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mmbd_pkg::result_t din,
    output logic              full,
    input  logic              pop,
    output mmbd_pkg::result_t dout,
    output logic              empty
);

    mmbd_pkg::result_t             entries_reg [mmbd_pkg::QUEUE_DEPTH];
    logic [mmbd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [mmbd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [mmbd_pkg::QCNT_W-1:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == mmbd_pkg::QCNT_W'(mmbd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + mmbd_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + mmbd_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + mmbd_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - mmbd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= din;
    end

    `MMBD_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= mmbd_pkg::QCNT_W'(mmbd_pkg::QUEUE_DEPTH), "result queue count overflow")
    `MMBD_ASSERT_NXT(a_ptr_gap, 1'b1, (wr_ptr_reg - rd_ptr_reg) == count_reg[mmbd_pkg::QPTR_W-1:0], "result queue pointers disagree with count")

endmodule

@@ src/mipmap_box_downsampler_core.sv @@
// mip chain generator with 2x2 box filter: top level
// a level 1 result passes the request queue, engine step and result queue registers
// throughput: one pixel per cycle; each extra emitting level below 1 adds one engine step
// the level engine sets the rate: one level step per cycle unless the result queue is full
// reset: 4096 x 4096 with four channels, all positions zero, queues empty
// reset: shared pair-sum memory and held pixels are not cleared and need no clearing pass
module mipmap_box_downsampler_core (
    input  logic                             clk,
    input  logic                             rst_n,

    // pixel request side, looks like a queue write port
    input  logic                             push,
    output logic                             full,
    input  logic [mmbd_pkg::CH_W-1:0]        pix_c0,
    input  logic [mmbd_pkg::CH_W-1:0]        pix_c1,
    input  logic [mmbd_pkg::CH_W-1:0]        pix_c2,
    input  logic [mmbd_pkg::CH_W-1:0]        pix_c3,

    // result side, looks like a queue read port
    output logic                             empty,
    input  logic                             pop,
    output logic [mmbd_pkg::LEVEL_W-1:0]     level,
    output logic [mmbd_pkg::POS_W-1:0]       col,
    output logic [mmbd_pkg::POS_W-1:0]       row,
    output logic [mmbd_pkg::CH_W-1:0]        out_c0,
    output logic [mmbd_pkg::CH_W-1:0]        out_c1,
    output logic [mmbd_pkg::CH_W-1:0]        out_c2,
    output logic [mmbd_pkg::CH_W-1:0]        out_c3,
    output logic                             last,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mmbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mmbd_pkg::DIM_W-1:0]       cfg_data
);

    mmbd_pkg::dims_t   dims;
    logic              restart;

    // front end to level engine
    mmbd_pkg::job_t    front_job;
    logic              front_push;
    logic              jq_full;
    mmbd_pkg::job_t    jq_head;
    logic              jq_empty;
    logic              jq_pop;

    // level engine to result queue
    mmbd_pkg::result_t eng_res;
    logic              eng_push;
    logic              oq_full;
    mmbd_pkg::result_t oq_head;

    // front end: holds the registers, counts the base raster position and
    // zeroes unused channels; a register write restarts the image
    mmbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pix_c0    (pix_c0),
        .pix_c1    (pix_c1),
        .pix_c2    (pix_c2),
        .pix_c3    (pix_c3),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_full  (jq_full),
        .job_push  (front_push),
        .job       (front_job),
        .dims      (dims),
        .restart   (restart)
    );

    // short queue so the input keeps flowing while the engine walks deeper levels
    mmbd_job_queue u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_job),
        .full  (jq_full),
        .pop   (jq_pop),
        .dout  (jq_head),
        .empty (jq_empty)
    );

    // level engine: each step feeds one pixel into one level; an emitting step
    // also folds in the next level's bookkeeping, and only cascades into a further step
    // when that level emits too
    mmbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dims      (dims),
        .restart   (restart),
        .job       (jq_head),
        .job_empty (jq_empty),
        .job_pop   (jq_pop),
        .res       (eng_res),
        .res_push  (eng_push),
        .res_full  (oq_full)
    );

    // result queue decouples the engine from a stalled consumer
    mmbd_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (eng_push),
        .din   (eng_res),
        .full  (oq_full),
        .pop   (pop),
        .dout  (oq_head),
        .empty (empty)
    );

    assign full   = jq_full;

    assign level  = oq_head.level;
    assign col    = oq_head.col;
    assign row    = oq_head.row;
    assign out_c0 = oq_head.px[0*mmbd_pkg::CH_W +: mmbd_pkg::CH_W];
    assign out_c1 = oq_head.px[1*mmbd_pkg::CH_W +: mmbd_pkg::CH_W];
    assign out_c2 = oq_head.px[2*mmbd_pkg::CH_W +: mmbd_pkg::CH_W];
    assign out_c3 = oq_head.px[3*mmbd_pkg::CH_W +: mmbd_pkg::CH_W];
    assign last   = oq_head.last;

endmodule
